// ----- hw/rtl/pswc_pkg.sv -----
package pswc_pkg;

   // field widths fixed by the stream format
   localparam int BYTE_W       = 8;
   localparam int POS_W        = 11;
   localparam int LEN_W        = 11;
   localparam int SUM_W        = 28;
   localparam int CSUM_W       = 27;
   localparam int OPA_W        = BYTE_W + 1;
   localparam int PROD_W       = OPA_W + POS_W + 1;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_FIELDS_W = BYTE_W + LEN_W + CSUM_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // default packet size limit
   localparam int PAYLOAD_MAX_DEF = 1024;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef logic [POS_W:0] pos_ext_type;

   // classified word handed from front to back
   typedef struct packed {
      logic [BYTE_W-1:0]       data_byte;
      logic                    last_byte;
      logic                    closing;
      logic [LEN_W-1:0]        length;
      logic [POS_W-1:0]        pos;
      logic signed [OPA_W-1:0] op_a;
      logic signed [BYTE_W-1:0] corr;
   } entry_type;

   // multiply stage contents in the back end
   typedef struct packed {
      logic [BYTE_W-1:0]         data_byte;
      logic                      last_byte;
      logic                      closing;
      logic [LEN_W-1:0]          length;
      logic signed [PROD_W-1:0]  prod;
      logic signed [BYTE_W-1:0]  corr;
   } mult_type;

   // result word held in the output register
   typedef struct packed {
      logic [BYTE_W-1:0]        out_byte;
      logic                     packet_end;
      logic                     last_packet;
      logic [LEN_W-1:0]         pkt_length;
      logic signed [CSUM_W-1:0] packet_checksum;
   } result_type;

   // handshake between two modules
   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

// ----- hw/rtl/packetizer_with_pair_swap_checksum_top.sv -----
// Packetizer with pair-swap checksum.
// Message bytes enter on the req_ stream, one byte per word, with req_tlast on
// the final byte of a message. Every byte comes back out on the rsp_ stream
// unchanged. A packet closes on the final message byte or when it holds
// PAYLOAD_MAX bytes; its closing word carries rsp_tlast, the packet length,
// the checksum and, in rsp_tuser, whether it is the last packet of the
// message. The checksum swaps bytes pairwise and sums signed byte times index.
// An accepted word passes the queue, the multiply stage and the output
// register to rsp_. Throughput: one byte per cycle unless rsp_ stalls,
// set by the single multiply-accumulate into the back-end running sum.
// Reset clears the packet position, the held byte, the running sum, the
// queue and the pipeline; the block accepts words right after reset.
// When the receiver stalls, the output register holds its word, the
// multiply stage and the two-word queue fill, and then req_tready drops.
module packetizer_with_pair_swap_checksum_top #(
   parameter int PAYLOAD_MAX = pswc_pkg::PAYLOAD_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pswc_pkg::REQ_TDATA_W-1:0] req_tdata,  // data_byte[7:0]
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_byte[7:0], pkt_length[18:8], packet_checksum[45:19], zero pad
   output logic [pswc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser   // last_packet
);
   import pswc_pkg::*;

   hs_type     push_hs, pop_hs;
   entry_type  push_entry, pop_entry;
   result_type res_word;

   // front end: packet position and classification
   pswc_front #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_data_byte (req_tdata[BYTE_W-1:0]),
      .in_last_byte (req_tlast),
      .push_ready   (push_hs.ready),
      .push_valid   (push_hs.valid),
      .push_entry   (push_entry)
   );

   // queue between front and back
   pswc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_hs.valid),
      .push_ready (push_hs.ready),
      .push_entry (push_entry),
      .pop_valid  (pop_hs.valid),
      .pop_ready  (pop_hs.ready),
      .pop_entry  (pop_entry)
   );

   // back end: multiply, accumulate, output register
   pswc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_hs.valid),
      .pop_ready (pop_hs.ready),
      .pop_entry (pop_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (res_word)
   );

   assign req_tready = push_hs.ready;

   // pack result fields onto the stream
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, res_word.packet_checksum,
                       res_word.pkt_length, res_word.out_byte};
   assign rsp_tlast = res_word.packet_end;
   assign rsp_tuser = res_word.last_packet;

endmodule

// ----- hw/rtl/pswc_front.sv -----
module pswc_front #(
   parameter int PAYLOAD_MAX = pswc_pkg::PAYLOAD_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [pswc_pkg::BYTE_W-1:0] in_data_byte,
   input  logic                        in_last_byte,
   input  logic                        push_ready,
   output logic                        push_valid,
   output pswc_pkg::entry_type         push_entry
);
   import pswc_pkg::*;

   localparam pos_ext_type LIMIT = pos_ext_type'(PAYLOAD_MAX);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   pos_ext_type       pos_plus;
   logic              closing;
   logic              accept;
   logic signed [OPA_W-1:0]  sb, sh;

   // classify the incoming byte against the packet position
   always_comb begin
      pos_plus = {1'b0, pos_ff} + pos_ext_type'(1);
      closing  = in_last_byte || (pos_plus >= LIMIT);
      sb       = OPA_W'($signed(in_data_byte));
      sh       = OPA_W'($signed(held_ff));
      push_entry.data_byte = in_data_byte;
      push_entry.last_byte = in_last_byte;
      push_entry.closing   = closing;
      push_entry.length    = pos_plus[LEN_W-1:0];
      push_entry.pos       = pos_ff;
      if (pos_ff[0]) begin
         // odd position: pair swap folds into pos*(b+h) - b
         push_entry.op_a = sb + sh;
         push_entry.corr = $signed(in_data_byte);
      end else if (closing) begin
         // trailing unpaired byte keeps its own index
         push_entry.op_a = sb;
         push_entry.corr = '0;
      end else begin
         push_entry.op_a = '0;
         push_entry.corr = '0;
      end
   end

   assign push_valid = in_valid;
   assign accept     = in_valid && push_ready;

   // position and held even byte
   always_comb begin
      pos_in  = pos_ff;
      held_in = held_ff;
      if (accept) begin
         if (closing) begin
            pos_in  = '0;
            held_in = '0;
         end else begin
            pos_in = pos_plus[POS_W-1:0];
            if (!pos_ff[0]) begin
               held_in = in_data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         held_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         held_ff <= held_in;
      end
   end

   // position never reaches the packet limit
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} < LIMIT)
      else $error("packet position beyond limit");

   // a final message byte restarts the packet
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && in_last_byte |=> pos_ff == '0 && held_ff == '0)
      else $error("packet state not cleared after last byte");

endmodule

// ----- hw/rtl/pswc_fifo.sv -----
module pswc_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  pswc_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output pswc_pkg::entry_type pop_entry
);
   import pswc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   entry_type        queue_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = queue_mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/pswc_back.sv -----
module pswc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  pswc_pkg::entry_type  pop_entry,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pswc_pkg::result_type out_word
);
   import pswc_pkg::*;

   hs_type                   mult_hs, res_hs;
   logic                     mult_valid_ff, mult_valid_in;
   mult_type                 mult_ff, mult_in;
   logic                     res_valid_ff, res_valid_in;
   result_type               res_ff, res_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [SUM_W-1:0]  total;
   logic                     mult_load, res_load;

   // stage handshakes: each stage takes a word when it is empty or draining
   always_comb begin
      res_hs.valid  = res_valid_ff;
      res_hs.ready  = !res_valid_ff || out_ready;
      mult_hs.valid = mult_valid_ff;
      mult_hs.ready = !mult_valid_ff || res_hs.ready;
   end

   assign pop_ready = mult_hs.ready;
   assign mult_load = pop_valid && mult_hs.ready;
   assign res_load  = mult_hs.valid && res_hs.ready;

   // multiply stage: position times folded byte pair
   always_comb begin
      mult_valid_in = mult_valid_ff;
      mult_in       = mult_ff;
      if (mult_hs.ready) begin
         mult_valid_in = pop_valid;
      end
      if (mult_load) begin
         mult_in.data_byte = pop_entry.data_byte;
         mult_in.last_byte = pop_entry.last_byte;
         mult_in.closing   = pop_entry.closing;
         mult_in.length    = pop_entry.length;
         mult_in.prod      = PROD_W'(pop_entry.op_a) *
                             PROD_W'($signed({1'b0, pop_entry.pos}));
         mult_in.corr      = pop_entry.corr;
      end
   end

   // accumulate stage and result word
   always_comb begin
      total        = sum_ff + SUM_W'(mult_ff.prod) - SUM_W'(mult_ff.corr);
      res_valid_in = res_valid_ff;
      res_in       = res_ff;
      sum_in       = sum_ff;
      if (res_hs.ready) begin
         res_valid_in = mult_hs.valid;
      end
      if (res_load) begin
         res_in.out_byte = mult_ff.data_byte;
         if (mult_ff.closing) begin
            res_in.packet_end      = 1'b1;
            res_in.last_packet     = mult_ff.last_byte;
            res_in.pkt_length      = mult_ff.length;
            res_in.packet_checksum = total[CSUM_W-1:0];
            sum_in                 = '0;
         end else begin
            res_in.packet_end      = 1'b0;
            res_in.last_packet     = 1'b0;
            res_in.pkt_length      = '0;
            res_in.packet_checksum = '0;
            sum_in                 = total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
         sum_ff        <= '0;
      end else begin
         mult_valid_ff <= mult_valid_in;
         res_valid_ff  <= res_valid_in;
         sum_ff        <= sum_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mult_ff <= mult_in;
      res_ff  <= res_in;
   end

   assign out_valid = res_valid_ff;
   assign out_word  = res_ff;

   // a closing word leaves the running sum cleared
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      res_load && mult_ff.closing |=> sum_ff == '0)
      else $error("running sum not cleared at packet end");

   // trailer fields are zero on words that do not close a packet
   a_trailer_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && !res_ff.packet_end |->
         res_ff.last_packet == 1'b0 && res_ff.pkt_length == '0 &&
         res_ff.packet_checksum == '0)
      else $error("trailer fields set without packet end");

endmodule
